[rtl/kmdc_pkg.sv]
// Shared types, sizes and helper functions for the k-way merge compactor.
package kmdc_pkg;

  // Design sizes.
  localparam int RUNS     = 8;
  localparam int KEY_BITS = 64;
  localparam int SEQ_BITS = 64;

  // Derived sizes for the selection tree.
  localparam int IDX_W  = (RUNS > 1) ? $clog2(RUNS) : 1;
  localparam int LEAVES = 2 ** IDX_W;
  localparam int NODES  = 2 * LEAVES - 1;

  // Configuration register widths and indexes.
  localparam int ACT_W = 4;
  localparam logic REG_ACTIVE_RUNS = 1'b0;
  localparam logic REG_DROP_TOMBS  = 1'b1;

  // Input request payload.
  typedef struct packed {
    logic [2:0]  run;
    logic [63:0] entry_key;
    logic [63:0] entry_seq;
    logic        entry_is_delete;
    logic        run_finished;
  } entry_t;

  // Result payload.
  typedef struct packed {
    logic        decided;
    logic        write_entry;
    logic [63:0] out_key;
    logic [63:0] out_seq;
    logic        out_is_delete;
    logic [7:0]  consumed_runs;
    logic        all_done;
    logic        protocol_error;
  } result_t;

  // View of one run's head after the current request is applied.
  typedef struct packed {
    logic                act;
    logic                full;
    logic                done;
    logic                del;
    logic [KEY_BITS-1:0] key;
    logic [SEQ_BITS-1:0] seq;
  } lane_t;

  // One candidate in the selection tree.
  typedef struct packed {
    logic                vld;
    logic                del;
    logic [KEY_BITS-1:0] key;
    logic [SEQ_BITS-1:0] seq;
    logic [IDX_W-1:0]    idx;
  } node_t;

  // Pick the better of two candidates: smaller key, then larger sequence,
  // then the left one, which always holds the lower run indexes.
  function automatic node_t pick(input node_t a, input node_t b);
    node_t r;
    r = a;
    if (!a.vld) begin
      r = b;
    end else if (b.vld) begin
      if (b.key < a.key) begin
        r = b;
      end else if ((b.key == a.key) && (b.seq > a.seq)) begin
        r = b;
      end
    end
    return r;
  endfunction

endpackage

[rtl/kmdc_heads.sv]
// Head registers of every run, request decode and head consumption.
module kmdc_heads (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  kmdc_pkg::entry_t             entry_q,
  input  logic [kmdc_pkg::ACT_W-1:0]   active_runs,
  input  logic [kmdc_pkg::RUNS-1:0]    consume,
  output kmdc_pkg::lane_t              lanes [kmdc_pkg::RUNS],
  output logic                         err
);

  logic [kmdc_pkg::KEY_BITS-1:0] head_key [kmdc_pkg::RUNS];
  logic [kmdc_pkg::SEQ_BITS-1:0] head_seq [kmdc_pkg::RUNS];
  logic [kmdc_pkg::RUNS-1:0]     head_delete;
  logic [kmdc_pkg::RUNS-1:0]     head_full;
  logic [kmdc_pkg::RUNS-1:0]     run_done;

  logic [kmdc_pkg::RUNS-1:0] act;
  logic [kmdc_pkg::RUNS-1:0] wr;
  logic [kmdc_pkg::RUNS-1:0] load;
  logic [kmdc_pkg::RUNS-1:0] full_mid;
  logic [kmdc_pkg::RUNS-1:0] done_mid;

  // Decode the target run and check that the request is legal for it.
  always_comb begin
    for (int i = 0; i < kmdc_pkg::RUNS; i++) begin
      act[i] = (i == 0) || ({1'b0, active_runs} > 5'(i));
      wr[i]  = (5'(entry_q.run) == 5'(i)) && act[i] && !head_full[i] && !run_done[i];
    end
    err      = ~|wr;
    load     = wr & {kmdc_pkg::RUNS{!entry_q.run_finished}};
    full_mid = head_full | load;
    done_mid = run_done | (wr & {kmdc_pkg::RUNS{entry_q.run_finished}});
  end

  // Present each head as it stands once the request is applied.
  always_comb begin
    for (int i = 0; i < kmdc_pkg::RUNS; i++) begin
      lanes[i].act  = act[i];
      lanes[i].full = full_mid[i];
      lanes[i].done = done_mid[i];
      lanes[i].del  = load[i] ? entry_q.entry_is_delete : head_delete[i];
      lanes[i].key  = load[i] ? entry_q.entry_key[kmdc_pkg::KEY_BITS-1:0] : head_key[i];
      lanes[i].seq  = load[i] ? entry_q.entry_seq[kmdc_pkg::SEQ_BITS-1:0] : head_seq[i];
    end
  end

  // Head contents are only read while the head is full, so they need no reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < kmdc_pkg::RUNS; i++) begin
      if (step && load[i]) begin
        head_key[i]    <= entry_q.entry_key[kmdc_pkg::KEY_BITS-1:0];
        head_seq[i]    <= entry_q.entry_seq[kmdc_pkg::SEQ_BITS-1:0];
        head_delete[i] <= entry_q.entry_is_delete;
      end
    end
  end

  // Full and ended flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_full <= '0;
      run_done  <= '0;
    end else if (step) begin
      head_full <= full_mid & ~consume;
      run_done  <= done_mid;
    end
  end

endmodule

[rtl/kmdc_select.sv]
// Compare tree that resolves the smallest key and its newest version.
module kmdc_select (
  input  kmdc_pkg::lane_t            lanes [kmdc_pkg::RUNS],
  output logic                       decided,
  output kmdc_pkg::node_t            winner,
  output logic [kmdc_pkg::RUNS-1:0]  consume,
  output logic                       all_done
);

  kmdc_pkg::node_t node [kmdc_pkg::NODES];

  logic ready;
  logic any;

  // Leaves: one per run, padded with empty candidates.
  for (genvar j = 0; j < kmdc_pkg::LEAVES; j++) begin : g_leaf
    if (j < kmdc_pkg::RUNS) begin : g_run
      assign node[kmdc_pkg::LEAVES-1+j] = '{
        vld: lanes[j].act && lanes[j].full,
        del: lanes[j].del,
        key: lanes[j].key,
        seq: lanes[j].seq,
        idx: kmdc_pkg::IDX_W'(j)
      };
    end else begin : g_pad
      assign node[kmdc_pkg::LEAVES-1+j] = '0;
    end
  end

  // Internal nodes of the tournament tree.
  for (genvar i = 0; i < kmdc_pkg::LEAVES - 1; i++) begin : g_node
    assign node[i] = kmdc_pkg::pick(node[2*i+1], node[2*i+2]);
  end

  assign winner = node[0];

  // Readiness, consumption mask and end of merge.
  always_comb begin
    ready    = 1'b1;
    any      = 1'b0;
    all_done = 1'b1;
    consume  = '0;
    for (int i = 0; i < kmdc_pkg::RUNS; i++) begin
      if (lanes[i].act) begin
        if (lanes[i].full) begin
          any = 1'b1;
        end else if (!lanes[i].done) begin
          ready = 1'b0;
        end
      end
    end
    decided = ready && any;
    for (int i = 0; i < kmdc_pkg::RUNS; i++) begin
      consume[i] = decided && lanes[i].act && lanes[i].full && (lanes[i].key == winner.key);
      if (lanes[i].act && ((lanes[i].full && !consume[i]) || !lanes[i].done)) begin
        all_done = 1'b0;
      end
    end
  end

endmodule

[rtl/kway_merge_dedup_compactor.sv]
// An accepted request waits in the input register until the result register is free.
// Throughput: one request per cycle while the result side does not stall; the
// head update, compare tree and consumption all settle between the two registers.
// Reset (rst, synchronous): clears all head full and run ended flags, empties
// both registers, and sets active_runs to 8 and drop_tombstones to 0.
module kway_merge_dedup_compactor (
  input  logic              clk,
  input  logic              rst,
  input  logic              entry_valid,
  output logic              entry_ready,
  input  kmdc_pkg::entry_t  entry,
  output logic              result_valid,
  input  logic              result_ready,
  output kmdc_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [kmdc_pkg::ACT_W-1:0] active_runs;
  logic                       drop_tombstones;

  kmdc_pkg::entry_t  entry_q;
  logic              entry_q_valid;
  logic              step;
  kmdc_pkg::result_t result_next;

  kmdc_pkg::lane_t           lanes [kmdc_pkg::RUNS];
  logic                      err;
  logic                      decided;
  kmdc_pkg::node_t           winner;
  logic [kmdc_pkg::RUNS-1:0] consume;
  logic                      all_done;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_runs     <= kmdc_pkg::ACT_W'(8);
      drop_tombstones <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        kmdc_pkg::REG_ACTIVE_RUNS: active_runs     <= pwdata[kmdc_pkg::ACT_W-1:0];
        kmdc_pkg::REG_DROP_TOMBS:  drop_tombstones <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      kmdc_pkg::REG_ACTIVE_RUNS: prdata = 32'(active_runs);
      kmdc_pkg::REG_DROP_TOMBS:  prdata = 32'(drop_tombstones);
    endcase
  end

  // Input register: a request is processed once the result register is free.
  assign step        = entry_q_valid && (!result_valid || result_ready);
  assign entry_ready = !entry_q_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_q_valid <= 1'b0;
    end else if (entry_valid && entry_ready) begin
      entry_q_valid <= 1'b1;
    end else if (step) begin
      entry_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_valid && entry_ready) begin
      entry_q <= entry;
    end
  end

  // Run heads and the decision tree.
  kmdc_heads u_heads (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .entry_q     (entry_q),
    .active_runs (active_runs),
    .consume     (consume),
    .lanes       (lanes),
    .err         (err)
  );

  kmdc_select u_select (
    .lanes    (lanes),
    .decided  (decided),
    .winner   (winner),
    .consume  (consume),
    .all_done (all_done)
  );

  // Assemble the result; winner fields read zero when nothing was decided.
  always_comb begin
    result_next                = '0;
    result_next.decided        = decided;
    result_next.all_done       = all_done;
    result_next.protocol_error = err;
    if (decided) begin
      result_next.write_entry   = !(winner.del && drop_tombstones);
      result_next.out_key       = 64'(winner.key);
      result_next.out_seq       = 64'(winner.seq);
      result_next.out_is_delete = winner.del;
      result_next.consumed_runs = 8'(consume);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  // An emitted entry is always a decided one.
  a_write_needs_decide: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.write_entry |-> result.decided)
    else $error("write_entry without decided");

  // A decision always consumes at least one head, and no decision consumes none.
  a_decide_consumes: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.decided == (result.consumed_runs != 8'd0)))
    else $error("consumed_runs does not match decided");

  // Every processed request leaves a result in the result register.
  a_step_fills_result: assert property (@(posedge clk) disable iff (rst)
    step |=> result_valid)
    else $error("processed request left no result");
`endif

endmodule

[bench/tb_kway_merge_dedup_compactor.sv]
// Self-checking testbench for the k-way merge compactor: directed table, then random merges.
`timescale 1ns / 1ps

module tb_kway_merge_dedup_compactor;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int PHASE_REQUESTS = 108;
  localparam int NUM_PHASES     = 7;
  localparam logic [63:0] ALL_ONES = '1;

  // One line of the directed plan: either a register change or a request.
  typedef struct {
    bit                reprogram;
    logic [3:0]        act;
    logic              drop;
    kmdc_pkg::entry_t  req;
    bit                fixed;
    kmdc_pkg::result_t want;
  } plan_row_t;

  typedef int run_list_t[$];

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              entry_valid = 1'b0;
  logic              entry_ready;
  kmdc_pkg::entry_t  entry = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  kmdc_pkg::result_t result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Merge state as the block should hold it.
  logic [kmdc_pkg::KEY_BITS-1:0] hd_key [kmdc_pkg::RUNS];
  logic [kmdc_pkg::SEQ_BITS-1:0] hd_seq [kmdc_pkg::RUNS];
  logic                          hd_del [kmdc_pkg::RUNS];
  logic                          hd_full [kmdc_pkg::RUNS];
  logic                          run_ended [kmdc_pkg::RUNS];
  logic [3:0]                    mode_active;
  logic                          mode_drop;

  kmdc_pkg::result_t pending_results[$];
  plan_row_t         plan[$];
  int                failures = 0;
  int                quiet_cycles = 0;
  bit                calm = 1'b0;
  bit                squeeze_req = 1'b0;
  bit                squeeze_taken = 1'b0;
  int                stall_left = 0;
  int                open_left = 0;

  kway_merge_dedup_compactor dut (.*);

  // Free-running clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Runs taking part, with out-of-range counts clamped.
  function automatic int live_runs();
    if (mode_active == 0) return 1;
    if (mode_active > kmdc_pkg::RUNS) return kmdc_pkg::RUNS;
    return int'(mode_active);
  endfunction

  // Active runs that are still open and wait for a refill.
  function automatic run_list_t open_runs_now();
    run_list_t list;
    for (int i = 0; i < live_runs(); i++) begin
      if (!run_ended[i] && !hd_full[i]) list.insert(list.size(), i);
    end
    return list;
  endfunction

  // Append one row to the directed plan.
  function automatic void add_row(plan_row_t p);
    plan.insert(plan.size(), p);
  endfunction

  // Apply one request to the merge state and return the result it causes.
  function automatic kmdc_pkg::result_t merge_step(kmdc_pkg::entry_t e);
    kmdc_pkg::result_t             r;
    int                            n;
    int                            w;
    bit                            ready;
    bit                            any;
    bit                            have;
    logic [kmdc_pkg::KEY_BITS-1:0] min_key;
    n = live_runs();
    r = '0;
    w = 0;
    ready = 1'b1;
    any = 1'b0;
    have = 1'b0;
    min_key = '0;
    if (e.run >= n || run_ended[e.run] || hd_full[e.run]) begin
      r.protocol_error = 1'b1;
    end else if (e.run_finished) begin
      run_ended[e.run] = 1'b1;
    end else begin
      hd_key[e.run]  = e.entry_key;
      hd_seq[e.run]  = e.entry_seq;
      hd_del[e.run]  = e.entry_is_delete;
      hd_full[e.run] = 1'b1;
    end

    // Ready once every active run has a head or has ended.
    for (int i = 0; i < n; i++) begin
      if (hd_full[i]) any = 1'b1;
      else if (!run_ended[i]) ready = 1'b0;
    end

    if (ready && any) begin
      for (int i = 0; i < n; i++) begin
        if (hd_full[i] && (!have || hd_key[i] < min_key)) begin
          min_key = hd_key[i];
          have = 1'b1;
        end
      end
      // Newest version of the smallest key wins; equal sequences keep the lower run.
      have = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (hd_full[i] && hd_key[i] == min_key) begin
          if (!have || hd_seq[i] > hd_seq[w]) begin
            w = i;
            have = 1'b1;
          end
          r.consumed_runs[i] = 1'b1;
        end
      end
      r.decided       = 1'b1;
      r.write_entry   = !(hd_del[w] && mode_drop);
      r.out_key       = hd_key[w];
      r.out_seq       = hd_seq[w];
      r.out_is_delete = hd_del[w];
      for (int i = 0; i < n; i++) begin
        if (r.consumed_runs[i]) hd_full[i] = 1'b0;
      end
    end

    r.all_done = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (hd_full[i] || !run_ended[i]) r.all_done = 1'b0;
    end
    return r;
  endfunction

  function automatic kmdc_pkg::entry_t load_req(int run, logic [63:0] key, logic [63:0] seq,
                                                bit del);
    kmdc_pkg::entry_t e;
    e = '0;
    e.run = 3'(run);
    e.entry_key = key;
    e.entry_seq = seq;
    e.entry_is_delete = del;
    return e;
  endfunction

  function automatic kmdc_pkg::entry_t end_req(int run);
    kmdc_pkg::entry_t e;
    e = '0;
    e.run = 3'(run);
    e.run_finished = 1'b1;
    return e;
  endfunction

  // A result that carries only the error and completion flags.
  function automatic kmdc_pkg::result_t quiet_res(bit err, bit done);
    kmdc_pkg::result_t r;
    r = '0;
    r.protocol_error = err;
    r.all_done = done;
    return r;
  endfunction

  function automatic plan_row_t step_row(kmdc_pkg::entry_t req, bit fixed = 1'b0,
                                         kmdc_pkg::result_t want = '0);
    plan_row_t p;
    p.reprogram = 1'b0;
    p.act = '0;
    p.drop = 1'b0;
    p.req = req;
    p.fixed = fixed;
    p.want = want;
    return p;
  endfunction

  function automatic plan_row_t mode_row(logic [3:0] act, logic drop);
    plan_row_t p;
    p = step_row('0);
    p.reprogram = 1'b1;
    p.act = act;
    p.drop = drop;
    return p;
  endfunction

  // Build the next random request. Mostly refills of open runs; some noise.
  // Outside the closing phase, noise never ends a run for real. When every
  // active head is full, a rejected request still lets the block resolve a key.
  function automatic bit make_request(bit closing, output kmdc_pkg::entry_t e);
    run_list_t open_runs;
    bit        waiting;
    bit        noise;
    open_runs = open_runs_now();
    waiting = 1'b0;
    for (int i = 0; i < live_runs(); i++) begin
      if (hd_full[i]) waiting = 1'b1;
    end
    e = '0;
    if (open_runs.size() == 0 && !waiting) return 1'b0;
    noise = (open_runs.size() == 0) || ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 3))
      0, 1: e.entry_key = {$urandom, $urandom};
      2: e.entry_key = 64'($urandom_range(0, 7));
      default: e.entry_key = ($urandom_range(0, 1) != 0) ? ALL_ONES : {1'b1, 63'd0};
    endcase
    case ($urandom_range(0, 3))
      0, 1: e.entry_seq = {$urandom, $urandom};
      2: e.entry_seq = 64'($urandom_range(0, 3));
      default: e.entry_seq = ALL_ONES;
    endcase
    e.entry_is_delete = 1'($urandom_range(0, 1));
    if (noise) begin
      e.run = 3'($urandom_range(0, 7));
      e.run_finished = 1'($urandom_range(0, 1));
      if (e.run_finished && !closing && e.run < live_runs() && !run_ended[e.run] &&
          !hd_full[e.run]) begin
        e.run_finished = 1'b0;
      end
    end else begin
      e.run = 3'(open_runs[$urandom_range(0, open_runs.size() - 1)]);
      e.run_finished = closing && ($urandom_range(0, 24) == 0);
    end
    return 1'b1;
  endfunction

  // Offer one request, record its expected result on acceptance, then maybe pause.
  task automatic drive_request(kmdc_pkg::entry_t e, kmdc_pkg::result_t want);
    int gap;
    int roll;
    entry <= e;
    entry_valid <= 1'b1;
    @(posedge clk);
    while (!entry_ready) @(posedge clk);
    pending_results.insert(pending_results.size(), want);
    roll = $urandom_range(0, 19);
    gap = calm ? 0 : (roll < 12) ? 0 : (roll < 18) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap > 0) begin
      entry_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write one register, then read it back.
  task automatic write_reg(logic idx, logic [31:0] val);
    logic [31:0] want;
    want = (idx == kmdc_pkg::REG_ACTIVE_RUNS) ? (val & 32'hF) : (val & 32'h1);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      failures++;
      if (failures <= 10) $display("register %0d read back %h, expected %h", idx, prdata, want);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Change the merge mode once the block has drained.
  task automatic set_mode(logic [3:0] act, logic drop);
    entry_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    write_reg(kmdc_pkg::REG_ACTIVE_RUNS, {28'd0, act});
    write_reg(kmdc_pkg::REG_DROP_TOMBS, {31'd0, drop});
    mode_active = act;
    mode_drop = drop;
  endtask

  // Result side: random stalls, plus one long hold-off to back the block up.
  always @(posedge clk) begin
    int roll;
    if (rst) begin
      result_ready <= 1'b0;
      stall_left <= 0;
      open_left <= 0;
    end else if (squeeze_req && !squeeze_taken) begin
      squeeze_taken <= 1'b1;
      stall_left <= SQUEEZE_CYCLES;
      result_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_ready <= 1'b0;
    end else if (open_left > 0) begin
      open_left <= open_left - 1;
      result_ready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 9);
      if (roll < 5) begin
        open_left <= $urandom_range(0, 40);
        result_ready <= 1'b1;
      end else if (roll < 9) begin
        stall_left <= $urandom_range(0, 2);
        result_ready <= 1'b0;
      end else begin
        stall_left <= $urandom_range(10, 30);
        result_ready <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    kmdc_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result with nothing expected: %p", result);
      end else begin
        want = pending_results.pop_front();
        if (result.decided !== want.decided || result.write_entry !== want.write_entry ||
            result.out_key !== want.out_key || result.out_seq !== want.out_seq ||
            result.out_is_delete !== want.out_is_delete ||
            result.consumed_runs !== want.consumed_runs ||
            result.all_done !== want.all_done ||
            result.protocol_error !== want.protocol_error) begin
          failures++;
          if (failures <= 10) begin
            $display("result mismatch, expected: %p", want);
            $display("                   actual: %p", result);
          end
        end
      end
    end
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk) begin
    if (rst || (entry_valid && entry_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus: directed table first, then random phases, then close every run.
  initial begin
    plan_row_t         cur;
    kmdc_pkg::result_t want;
    kmdc_pkg::entry_t  req;
    run_list_t         open_runs;
    int                counted;
    logic [3:0]        act_list [NUM_PHASES];
    bit                drop_list [NUM_PHASES];
    bit                more;

    for (int i = 0; i < kmdc_pkg::RUNS; i++) begin
      hd_key[i] = '0;
      hd_seq[i] = '0;
      hd_del[i] = 1'b0;
      hd_full[i] = 1'b0;
      run_ended[i] = 1'b0;
    end
    mode_active = 4'd8;
    mode_drop = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: eight runs, tombstones kept.
    add_row(step_row(load_req(0, ALL_ONES, 64'd0, 1'b0), 1'b1, quiet_res(1'b0, 1'b0)));
    // Refill of a full head, then an end while the head is still full.
    add_row(step_row(load_req(0, 64'd5, 64'd5, 1'b1), 1'b1, quiet_res(1'b1, 1'b0)));
    add_row(step_row(end_req(0), 1'b1, quiet_res(1'b1, 1'b0)));
    add_row(step_row(load_req(1, ALL_ONES, ALL_ONES, 1'b1)));
    add_row(step_row(load_req(2, 64'd0, 64'd5, 1'b0)));
    add_row(step_row(load_req(3, 64'd0, 64'd5, 1'b0)));
    add_row(step_row(load_req(4, 64'd0, 64'd3, 1'b1)));
    add_row(step_row(load_req(5, 64'd7, 64'd9, 1'b1)));
    add_row(step_row(load_req(6, 64'd7, 64'd9, 1'b0)));
    // Ending the last run makes the merge ready: key zero from three runs.
    add_row(step_row(end_req(7)));
    add_row(step_row(load_req(2, 64'd7, 64'd10, 1'b1)));
    add_row(step_row(load_req(3, 64'd7, 64'd10, 1'b0)));
    add_row(step_row(load_req(4, 64'd8, 64'd1, 1'b0)));
    // Zero active runs acts as one; a rejected request still lets run 0 resolve.
    add_row(mode_row(4'd0, 1'b1));
    add_row(step_row(load_req(1, 64'd1, 64'd1, 1'b0)));
    add_row(step_row(load_req(0, ALL_ONES, ALL_ONES, 1'b1)));
    // Counts above the run total act as all runs; parked heads come back.
    add_row(mode_row(4'd15, 1'b1));
    add_row(step_row(load_req(0, 64'd3, 64'd1, 1'b1)));
    add_row(step_row(load_req(2, 64'd3, 64'd2, 1'b0)));
    add_row(step_row(load_req(3, 64'd3, 64'd0, 1'b1)));
    add_row(step_row(load_req(5, 64'd100, ALL_ONES, 1'b0)));
    add_row(step_row(load_req(6, 64'd9, 64'd0, 1'b1)));
    // Refill of a run that has already ended.
    add_row(step_row(load_req(7, 64'd1, 64'd1, 1'b0), 1'b1, quiet_res(1'b1, 1'b0)));

    foreach (plan[k]) begin
      cur = plan[k];
      if (cur.reprogram) begin
        set_mode(cur.act, cur.drop);
      end else begin
        want = merge_step(cur.req);
        drive_request(cur.req, cur.fixed ? cur.want : want);
      end
    end

    // Random phases over a spread of settings; only the last one ends runs.
    act_list = '{4'd8, 4'd1, 4'd2, 4'd15, 4'd0, 4'($urandom_range(3, 7)), 4'd8};
    drop_list = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1))};
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_mode(act_list[p], drop_list[p]);
      calm = (p == 0) || ($urandom_range(0, 3) == 0);
      if (p == 0) squeeze_req = 1'b1;
      counted = 0;
      while (counted < PHASE_REQUESTS && make_request(p == NUM_PHASES - 1, req)) begin
        want = merge_step(req);
        drive_request(req, want);
        if (!want.protocol_error) counted++;
      end
    end

    // Close every remaining run so the merge completes.
    calm = 1'b0;
    more = 1'b1;
    while (more) begin
      open_runs = open_runs_now();
      more = (open_runs.size() != 0);
      if (more) begin
        req = end_req(open_runs[$urandom_range(0, open_runs.size() - 1)]);
        want = merge_step(req);
        drive_request(req, want);
      end
    end
    // Requests after completion are all rejected.
    req = end_req(0);
    want = merge_step(req);
    drive_request(req, want);
    req = load_req($urandom_range(0, 7), {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    want = merge_step(req);
    drive_request(req, want);

    entry_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
